FILE: rtl/weighted_vertex_smoothing_defines.svh
// ---------------------------------------------------------------------------
// Weighted vertex smoothing: assertion macros
// Short forms for the concurrent checks kept in the smoothing block.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_VERTEX_SMOOTHING_DEFINES_SVH
`define WEIGHTED_VERTEX_SMOOTHING_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define WVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define WVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/wvs_pkg.sv
// ---------------------------------------------------------------------------
// Weighted vertex smoothing: shared package
// Widths, register indexes, kernel codes and divider handshake types.
// ---------------------------------------------------------------------------
package wvs_pkg;

   localparam int WVS_EXP_DEPTH_DEFAULT = 256;
   localparam int EXP_ENTRY_W = 33;   // Q1.32 sample, entry 0 is exactly 1.0

   localparam int POS_W  = 32;
   localparam int SUM_W  = 64;
   localparam int TOT_W  = 48;
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_MODE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RELAX_FACTOR    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DISTANCE_OFFSET = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAUSS_SCALE     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INCLUDE_CENTER  = 3'd4;

   // kernel codes; the spare code also runs the Gaussian kernel
   localparam logic [1:0] KERNEL_UNIFORM = 2'd0;
   localparam logic [1:0] KERNEL_INVERSE = 2'd1;
   localparam logic [1:0] KERNEL_GAUSS   = 2'd2;
   localparam logic [1:0] KERNEL_SPARE   = 2'd3;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/wvs_div.sv
// ---------------------------------------------------------------------------
// Weighted vertex smoothing: restoring divider
// Unsigned 64 by 48 bit division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wvs_div
   import wvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEPS = DIV_NUM_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;

   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         rem_in  = '0;
         den_in  = req.divisor;
         quo_in  = req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

FILE: rtl/wvs_exp_rom.sv
// ---------------------------------------------------------------------------
// Weighted vertex smoothing: exponential table
// Samples of exp(-x) over 0..16 in Q1.32, built at elaboration, registered read.
// ---------------------------------------------------------------------------
module wvs_exp_rom
   import wvs_pkg::*;
#(
   parameter int DEPTH = WVS_EXP_DEPTH_DEFAULT
)
(
   input  logic                           clock,
   input  logic [$clog2(DEPTH + 1)-1:0]   addr,
   output logic [EXP_ENTRY_W-1:0]         data
);

   localparam int          TAB_W = (DEPTH + 1) * EXP_ENTRY_W;
   localparam logic [63:0] STEP  = (64'd16 << 32) / DEPTH;

   function automatic logic [TAB_W-1:0] build_table();
      logic [TAB_W-1:0] tab;
      logic [63:0]      mag;
      logic [63:0]      r;
      logic [63:0]      e;
      tab = '0;
      mag = 64'd1 << 32;
      r   = mag;
      // exp(-step) by a truncated series
      for (int n = 1; n <= 24; n++) begin
         mag = ((mag * STEP) >> 32) / 64'(n);
         if (n % 2 == 1) r = r - mag;
         else            r = r + mag;
      end
      e = 64'd1 << 32;
      tab[0 +: EXP_ENTRY_W] = EXP_ENTRY_W'(e);
      for (int i = 1; i <= DEPTH; i++) begin
         e = (e * r + (64'd1 << 31)) >> 32;
         tab[i*EXP_ENTRY_W +: EXP_ENTRY_W] = EXP_ENTRY_W'(e);
      end
      return tab;
   endfunction

   localparam logic [TAB_W-1:0] EXP_TAB = build_table();

   logic [EXP_ENTRY_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      data_ff <= EXP_TAB[addr*EXP_ENTRY_W +: EXP_ENTRY_W];
   end

   assign data = data_ff;

endmodule

FILE: rtl/weighted_vertex_smoothing.sv
// ---------------------------------------------------------------------------
// Weighted vertex smoothing
// Relaxes one mesh vertex towards the kernel-weighted mean of its neighbours.
// ---------------------------------------------------------------------------
//  channel  direction  transfer carries
//  req_     in         one position; tuser marks centre and mask, tlast closes run
//  rsp_     out        one smoothed position per closed run
//  csr_     in         register write, index and data, no read-back
//
//  Steps per item: uniform kernel weights at once; Gaussian squares, scales,
//  looks up and interpolates (stops early when the exponent runs off the
//  table); inverse distance squares, takes 32 root steps and a divide (none
//  when the distance is zero); a centre left out of the sums ends at once.
//  A closing item adds a decide step, three lanes (divider start, divide, three
//  blend steps) and an emit step; a masked or unweighted vertex skips the lanes.
//  One shared 34x34 multiplier serves squares, exponent, interpolation,
//  weighting and the blend; one divider serves reciprocal and mean.
//  Reset is synchronous; it clears control state and sums, and loads the
//  register defaults; no item is taken while a run step is in progress, and a
//  result waiting on rsp_ holds the closing step until the output register frees.
// ---------------------------------------------------------------------------
`include "weighted_vertex_smoothing_defines.svh"

module weighted_vertex_smoothing
   import wvs_pkg::*;
#(
   parameter int EXP_TABLE_DEPTH = WVS_EXP_DEPTH_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,   // pos_x, pos_y, pos_z
   input  logic [1:0]            req_tuser,   // is_first, vertex_masked
   input  logic                  req_tlast,   // is_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [95:0]           rsp_tdata,   // out_x, out_y, out_z
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH + 1);

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DIFF = 5'd1;
   localparam logic [4:0] S_SQ0  = 5'd2;
   localparam logic [4:0] S_SQ1  = 5'd3;
   localparam logic [4:0] S_SQ2  = 5'd4;
   localparam logic [4:0] S_SQ3  = 5'd5;
   localparam logic [4:0] S_SQRT = 5'd6;
   localparam logic [4:0] S_INV  = 5'd7;
   localparam logic [4:0] S_IDIV = 5'd8;
   localparam logic [4:0] S_G0   = 5'd9;
   localparam logic [4:0] S_G1   = 5'd10;
   localparam logic [4:0] S_G2   = 5'd11;
   localparam logic [4:0] S_G3   = 5'd12;
   localparam logic [4:0] S_G4   = 5'd13;
   localparam logic [4:0] S_G5   = 5'd14;
   localparam logic [4:0] S_G6   = 5'd15;
   localparam logic [4:0] S_G7   = 5'd16;
   localparam logic [4:0] S_WM0  = 5'd17;
   localparam logic [4:0] S_WM1  = 5'd18;
   localparam logic [4:0] S_WM2  = 5'd19;
   localparam logic [4:0] S_WM3  = 5'd20;
   localparam logic [4:0] S_FIN  = 5'd21;
   localparam logic [4:0] S_FDIV = 5'd22;
   localparam logic [4:0] S_MDIV = 5'd23;
   localparam logic [4:0] S_R0   = 5'd24;
   localparam logic [4:0] S_R1   = 5'd25;
   localparam logic [4:0] S_R2   = 5'd26;
   localparam logic [4:0] S_EMIT = 5'd27;

   localparam logic [31:0] ONE_Q16   = 32'd65536;
   localparam logic [63:0] SQRT_TOP  = 64'd1 << 62;
   localparam logic [TOT_W-1:0] TOT_MAX = '1;

   // configuration
   logic [1:0]         kmode_ff, kmode_in;
   logic signed [18:0] relax_ff, relax_in;
   logic [30:0]        doff_ff, doff_in;
   logic [31:0]        gscale_ff, gscale_in;
   logic               incl_ff, incl_in;

   // run state
   logic [4:0]                state_ff, state_in;
   logic signed [POS_W-1:0]   pos_ff [3];
   logic signed [POS_W-1:0]   pos_in [3];
   logic signed [POS_W-1:0]   center_ff [3];
   logic signed [POS_W-1:0]   center_in [3];
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [SUM_W-1:0]   sum_in [3];
   logic [TOT_W-1:0]          total_ff, total_in;
   logic                      masked_ff, masked_in;
   logic                      last_ff, last_in;

   // working registers
   logic [32:0]               diff_ff [3];
   logic [32:0]               diff_in [3];
   logic [63:0]               d2_ff, d2_in;
   logic [63:0]               root_ff, root_in;
   logic [63:0]               bit_ff, bit_in;
   logic [31:0]               w_ff, w_in;
   logic [19:0]               e_ff, e_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic [19:0]               frac_ff, frac_in;
   logic [EXP_ENTRY_W-1:0]    t0_ff, t0_in;
   logic signed [67:0]        prod_ff, prod_in;
   logic signed [67:0]        vacc_ff, vacc_in;
   logic signed [31:0]        mean_ff, mean_in;
   logic [1:0]                lane_ff, lane_in;
   logic signed [POS_W-1:0]   res_ff [3];
   logic signed [POS_W-1:0]   res_in [3];

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [95:0]               rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [33:0]        mul_a, mul_b;
   div_req_type               div_req;
   div_rsp_type               div_rsp;
   logic [ADDR_W-1:0]         rom_addr;
   logic [EXP_ENTRY_W-1:0]    rom_data;

   // scratch
   logic                      accept;
   logic                      accept_busy;
   logic signed [19:0]        omr;
   logic signed [32:0]        sdiff;
   logic [64:0]               d2_sum;
   logic [63:0]               root_bit;
   logic [32:0]               dist_sum;
   logic [32:0]               esum;
   logic [33:0]               wround;
   logic [32:0]               interp;
   logic signed [64:0]        acc_sum;
   logic [TOT_W:0]            tot_sum;
   logic [63:0]               quo;
   logic signed [67:0]        blend;
   logic signed [67:0]        rounded;
   logic                      out_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign omr        = 20'sd65536 - 20'(relax_ff);
   // a centre left out of the sums that does not close the run ends at once
   assign accept_busy = accept && !(req_tuser[0] && !incl_ff && !req_tlast);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQ0: begin
            mul_a = {1'b0, diff_ff[0]};
            mul_b = {1'b0, diff_ff[0]};
         end
         S_SQ1: begin
            mul_a = {1'b0, diff_ff[1]};
            mul_b = {1'b0, diff_ff[1]};
         end
         S_SQ2: begin
            mul_a = {1'b0, diff_ff[2]};
            mul_b = {1'b0, diff_ff[2]};
         end
         S_G0: begin
            mul_a = {2'b0, gscale_ff};
            mul_b = {2'b0, d2_ff[63:32]};
         end
         S_G1: begin
            mul_a = {2'b0, gscale_ff};
            mul_b = {2'b0, d2_ff[31:0]};
         end
         S_G3: begin
            mul_a = {14'b0, e_ff};
            mul_b = 34'(EXP_TABLE_DEPTH);
         end
         S_G6: begin
            mul_a = {1'b0, t0_ff - rom_data};
            mul_b = {14'b0, frac_ff};
         end
         S_WM0: begin
            mul_a = {2'b0, w_ff};
            mul_b = 34'(pos_ff[0]);
         end
         S_WM1: begin
            mul_a = {2'b0, w_ff};
            mul_b = 34'(pos_ff[1]);
         end
         S_WM2: begin
            mul_a = {2'b0, w_ff};
            mul_b = 34'(pos_ff[2]);
         end
         S_R0: begin
            mul_a = 34'(omr);
            mul_b = 34'(center_ff[lane_ff]);
         end
         S_R1: begin
            mul_a = 34'(relax_ff);
            mul_b = 34'(mean_ff);
         end
         default: begin
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // exponential table address: first sample, then its successor
   always_comb begin
      if (state_ff == S_G4) rom_addr = prod_ff[20 +: ADDR_W];
      else                  rom_addr = idx_ff + ADDR_W'(1);
   end

   // divider request
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = 64'd1 << 32;
      div_req.divisor  = DIV_DEN_W'(dist_sum);
      if (state_ff == S_INV) begin
         div_req.start = (dist_sum != '0);
      end else if (state_ff == S_FDIV) begin
         div_req.start    = 1'b1;
         div_req.dividend = sum_ff[lane_ff][SUM_W-1] ? 64'(-sum_ff[lane_ff])
                                                      : 64'(sum_ff[lane_ff]);
         div_req.divisor  = total_ff;
      end
   end

   // sequencer and datapath next state
   always_comb begin
      kmode_in  = kmode_ff;
      relax_in  = relax_ff;
      doff_in   = doff_ff;
      gscale_in = gscale_ff;
      incl_in   = incl_ff;
      state_in  = state_ff;
      pos_in    = pos_ff;
      center_in = center_ff;
      sum_in    = sum_ff;
      total_in  = total_ff;
      masked_in = masked_ff;
      last_in   = last_ff;
      diff_in   = diff_ff;
      d2_in     = d2_ff;
      root_in   = root_ff;
      bit_in    = bit_ff;
      w_in      = w_ff;
      e_in      = e_ff;
      idx_in    = idx_ff;
      frac_in   = frac_ff;
      t0_in     = t0_ff;
      vacc_in   = vacc_ff;
      mean_in   = mean_ff;
      lane_in   = lane_ff;
      res_in    = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      sdiff    = '0;
      d2_sum   = {1'b0, d2_ff} + {1'b0, prod_ff[63:0]};
      root_bit = root_ff + bit_ff;
      dist_sum = {1'b0, root_ff[31:0]} + {2'b0, doff_ff};
      esum     = {13'b0, e_ff} + {1'b0, prod_ff[63:32]};
      interp   = t0_ff - prod_ff[52:20];
      wround   = {1'b0, interp} + 34'd32768;
      acc_sum  = '0;
      tot_sum  = {1'b0, total_ff} + {17'b0, w_ff};
      quo      = div_rsp.quotient;
      blend    = vacc_ff + prod_ff;
      rounded  = (blend + 68'sd32768) >>> 16;

      // register writes
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_KERNEL_MODE:     kmode_in  = csr_wdata[1:0];
            CSR_RELAX_FACTOR:    relax_in  = csr_wdata[18:0];
            CSR_DISTANCE_OFFSET: doff_in   = csr_wdata[30:0];
            CSR_GAUSS_SCALE:     gscale_in = csr_wdata;
            CSR_INCLUDE_CENTER:  incl_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               for (int j = 0; j < 3; j++) pos_in[j] = req_tdata[j*POS_W +: POS_W];
               last_in = req_tlast;
               lane_in = '0;
               state_in = S_DIFF;
               if (req_tuser[0]) begin
                  // centre opens a run: clear sums, keep mask
                  for (int j = 0; j < 3; j++) begin
                     center_in[j] = req_tdata[j*POS_W +: POS_W];
                     sum_in[j]    = '0;
                  end
                  total_in  = '0;
                  masked_in = req_tuser[1];
                  if (!incl_ff) state_in = req_tlast ? S_FIN : S_IDLE;
               end
            end
         end
         S_DIFF: begin
            for (int j = 0; j < 3; j++) begin
               sdiff      = {pos_ff[j][31], pos_ff[j]} - {center_ff[j][31], center_ff[j]};
               diff_in[j] = sdiff[32] ? 33'(-sdiff) : 33'(sdiff);
            end
            if (kmode_ff == KERNEL_UNIFORM) begin
               w_in     = ONE_Q16;
               state_in = S_WM0;
            end else begin
               state_in = S_SQ0;
            end
         end
         S_SQ0: state_in = S_SQ1;
         S_SQ1: begin
            d2_in    = prod_ff[63:0];
            state_in = S_SQ2;
         end
         S_SQ2: begin
            d2_in    = d2_sum[64] ? '1 : d2_sum[63:0];
            state_in = S_SQ3;
         end
         S_SQ3: begin
            d2_in    = d2_sum[64] ? '1 : d2_sum[63:0];
            root_in  = '0;
            bit_in   = SQRT_TOP;
            state_in = (kmode_ff == KERNEL_INVERSE) ? S_SQRT : S_G0;
         end
         S_SQRT: begin
            // one root digit per cycle, remainder kept in d2
            if (d2_ff >= root_bit) begin
               d2_in   = d2_ff - root_bit;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) state_in = S_INV;
         end
         S_INV: begin
            if (dist_sum == '0) begin
               w_in     = '0;
               state_in = S_WM0;
            end else begin
               state_in = S_IDIV;
            end
         end
         S_IDIV: begin
            if (div_rsp.done) begin
               w_in     = (quo[63:32] != '0) ? '1 : quo[31:0];
               state_in = S_WM0;
            end
         end
         S_G0: state_in = S_G1;
         S_G1: begin
            if (prod_ff[67:20] != '0) begin
               w_in     = '0;
               state_in = S_WM0;
            end else begin
               e_in     = prod_ff[19:0];
               state_in = S_G2;
            end
         end
         S_G2: begin
            if (esum[32:20] != '0) begin
               w_in     = '0;
               state_in = S_WM0;
            end else begin
               e_in     = esum[19:0];
               state_in = S_G3;
            end
         end
         S_G3: state_in = S_G4;
         S_G4: begin
            idx_in   = prod_ff[20 +: ADDR_W];
            frac_in  = prod_ff[19:0];
            state_in = S_G5;
         end
         S_G5: begin
            t0_in    = rom_data;
            state_in = S_G6;
         end
         S_G6: state_in = S_G7;
         S_G7: begin
            w_in     = 32'(wround[33:16]);
            state_in = S_WM0;
         end
         S_WM0: state_in = S_WM1;
         S_WM1: begin
            acc_sum   = {sum_ff[0][63], sum_ff[0]} + {prod_ff[63], prod_ff[63:0]};
            sum_in[0] = (acc_sum[64] != acc_sum[63]) ? {acc_sum[64], {63{~acc_sum[64]}}}
                                                     : acc_sum[63:0];
            state_in  = S_WM2;
         end
         S_WM2: begin
            acc_sum   = {sum_ff[1][63], sum_ff[1]} + {prod_ff[63], prod_ff[63:0]};
            sum_in[1] = (acc_sum[64] != acc_sum[63]) ? {acc_sum[64], {63{~acc_sum[64]}}}
                                                     : acc_sum[63:0];
            state_in  = S_WM3;
         end
         S_WM3: begin
            acc_sum   = {sum_ff[2][63], sum_ff[2]} + {prod_ff[63], prod_ff[63:0]};
            sum_in[2] = (acc_sum[64] != acc_sum[63]) ? {acc_sum[64], {63{~acc_sum[64]}}}
                                                     : acc_sum[63:0];
            total_in  = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
            state_in  = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            // pass the centre through when masked or nothing was weighted
            if (masked_ff || total_ff == '0) begin
               res_in   = center_ff;
               state_in = S_EMIT;
            end else begin
               state_in = S_FDIV;
            end
         end
         S_FDIV: state_in = S_MDIV;
         S_MDIV: begin
            if (div_rsp.done) begin
               if (sum_ff[lane_ff][SUM_W-1]) begin
                  mean_in = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quo[31:0]);
               end else begin
                  mean_in = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo[31:0]);
               end
               state_in = S_R0;
            end
         end
         S_R0: state_in = S_R1;
         S_R1: begin
            vacc_in  = prod_ff;
            state_in = S_R2;
         end
         S_R2: begin
            if (rounded[67:31] != '0 && rounded[67:31] != '1) begin
               res_in[lane_ff] = rounded[67] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               res_in[lane_ff] = rounded[31:0];
            end
            if (lane_ff == 2'd2) begin
               state_in = S_EMIT;
            end else begin
               lane_in  = lane_ff + 2'd1;
               state_in = S_FDIV;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_ff[2], res_ff[1], res_ff[0]};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmode_ff     <= KERNEL_INVERSE;
         relax_ff     <= 19'sd65536;
         doff_ff      <= '0;
         gscale_ff    <= 32'd32768;
         incl_ff      <= 1'b1;
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         masked_ff    <= 1'b0;
         last_ff      <= 1'b0;
         lane_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            center_ff[j] <= '0;
            sum_ff[j]    <= '0;
         end
      end else begin
         kmode_ff     <= kmode_in;
         relax_ff     <= relax_in;
         doff_ff      <= doff_in;
         gscale_ff    <= gscale_in;
         incl_ff      <= incl_in;
         state_ff     <= state_in;
         total_ff     <= total_in;
         masked_ff    <= masked_in;
         last_ff      <= last_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
         center_ff    <= center_in;
         sum_ff       <= sum_in;
      end
      pos_ff      <= pos_in;
      diff_ff     <= diff_in;
      d2_ff       <= d2_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      w_ff        <= w_in;
      e_ff        <= e_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      t0_ff       <= t0_in;
      prod_ff     <= prod_in;
      vacc_ff     <= vacc_in;
      mean_ff     <= mean_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   wvs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   wvs_exp_rom #(
      .DEPTH (EXP_TABLE_DEPTH)
   ) u_exp_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks on the sequencer
   `WVS_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept_busy, !req_tready, "ready after transfer")
   `WVS_ASSERT_NOW(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy, "divider busy")
   `WVS_ASSERT_NEXT(a_emit_loads, clock, reset, (state_ff == S_EMIT) && out_free, rsp_tvalid, "no result")

endmodule

FILE: bench/weighted_vertex_smoothing_tb.sv
// ----------------------------------------------------------------------------
// Weighted vertex smoothing testbench
// Sends runs of centre and neighbour positions under several kernel settings,
// predicts each smoothed vertex in a bit-true model of the block (or takes the
// typed one of a directed row) and compares every rsp_ transfer with the oldest
// prediction; both sides stall at random in all but the last two settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module weighted_vertex_smoothing_tb;
   import wvs_pkg::*;

   localparam int EXP_DEPTH   = WVS_EXP_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT  = 20000;   // cycles without any transfer
   localparam int DRAIN_WAIT  = 400;     // longer than a closing inverse-kernel step
   localparam int RANDOM_ITEMS = 900;
   localparam longint unsigned TOTAL_CAP = (64'd1 << 48) - 64'd1;
   localparam longint unsigned EXP_RANGE = 64'd16 << 16;

   typedef struct {
      int x, y, z;
   } vertex_type;

   // one row of the directed table; has_fixed selects the typed expectation
   typedef struct {
      int   x, y, z;
      bit   first, last, masked;
      bit   has_fixed;
      int   ex, ey, ez;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [95:0]           req_tdata;
   logic [1:0]            req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [95:0]           rsp_tdata;
   logic                  csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   weighted_vertex_smoothing u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // pos_x, pos_y, pos_z
      .req_tuser  (req_tuser),    // is_first, vertex_masked
      .req_tlast  (req_tlast),    // is_last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // out_x, out_y, out_z
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow of the block: registers, run state and exponential table
   // ---------------------------------------------------------------------
   logic [1:0]        kern_mode;
   longint            lambda;
   longint unsigned   dist_offset;
   longint unsigned   gauss_gain;
   bit                centre_in_sum;

   longint            centre_pos [3];
   longint            wsum       [3];
   longint unsigned   wtotal;
   bit                centre_masked;
   longint unsigned   exp_samples [0:EXP_DEPTH];

   vertex_type smoothed_q [$];
   int      mismatches;
   int      send_idle_pct, recv_idle_pct;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic void build_exp_samples();
      longint unsigned step, mag, ratio;
      step  = (64'd16 << 32) / EXP_DEPTH;
      mag   = 64'd1 << 32;
      ratio = mag;
      for (int n = 1; n <= 24; n++) begin
         mag = ((mag * step) >> 32) / n;
         if (n % 2 == 1) ratio -= mag; else ratio += mag;
      end
      exp_samples[0] = 64'd1 << 32;
      for (int i = 1; i <= EXP_DEPTH; i++)
         exp_samples[i] = (exp_samples[i-1] * ratio + (64'd1 << 31)) >> 32;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitpos;
      root   = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v    = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic longint clamp_q16(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint add_sat(input longint a, input longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, 64'h7FFF_FFFF_FFFF_FFFF})) return 64'h7FFF_FFFF_FFFF_FFFF;
      if (s < $signed({1'b1, 64'h8000_0000_0000_0000})) return 64'h8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic longint unsigned gauss_weight(input longint unsigned d2);
      longint unsigned e, prod, idx, rem, t0, t1, v;
      e = gauss_gain * (d2 >> 32);
      if (e >= EXP_RANGE) return 0;
      e += (gauss_gain * (d2 & 64'hFFFF_FFFF)) >> 32;
      if (e >= EXP_RANGE) return 0;
      prod = e * EXP_DEPTH;
      idx  = prod / EXP_RANGE;
      rem  = prod % EXP_RANGE;
      t0   = exp_samples[idx];
      t1   = exp_samples[idx+1];
      v    = t0 - ((t0 - t1) * rem) / EXP_RANGE;
      return (v + 64'd32768) >> 16;
   endfunction

   function automatic longint unsigned kernel_weight(input longint p [3]);
      longint unsigned d2, sq, u, d, q;
      longint          diff;
      if (kern_mode == KERNEL_UNIFORM) return 64'd65536;
      d2 = 0;
      for (int j = 0; j < 3; j++) begin
         diff = p[j] - centre_pos[j];
         u    = diff < 0 ? -diff : diff;
         sq   = u * u;
         d2   = (d2 > ~sq) ? 64'hFFFF_FFFF_FFFF_FFFF : d2 + sq;
      end
      if (kern_mode == KERNEL_INVERSE) begin
         d = int_sqrt(d2) + dist_offset;
         if (d == 0) return 0;
         q = (64'd1 << 32) / d;
         return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
      end
      return gauss_weight(d2);
   endfunction

   function automatic void add_to_sums(input longint p [3]);
      longint unsigned w;
      w = kernel_weight(p);
      for (int j = 0; j < 3; j++)
         wsum[j] = add_sat(wsum[j], longint'(w) * p[j]);
      wtotal += w;
      if (wtotal > TOTAL_CAP) wtotal = TOTAL_CAP;
   endfunction

   // Advance the shadow by one accepted item; return 1 with the smoothed vertex
   // when the item closes a run.
   function automatic bit smooth_step(input int x, input int y, input int z,
                                      input bit first, input bit last,
                                      input bit masked, output vertex_type res);
      longint p [3];
      longint mean, v, r [3];
      p[0] = x; p[1] = y; p[2] = z;
      if (first) begin
         for (int j = 0; j < 3; j++) begin
            centre_pos[j] = p[j];
            wsum[j]       = 0;
         end
         wtotal        = 0;
         centre_masked = masked;
         if (centre_in_sum) add_to_sums(p);
      end else begin
         add_to_sums(p);
      end
      if (!last) return 0;
      for (int j = 0; j < 3; j++) begin
         r[j] = centre_pos[j];
         if (!centre_masked && wtotal != 0) begin
            mean = clamp_q16(wsum[j] / longint'(wtotal));
            v    = (64'sd65536 - lambda) * centre_pos[j] + lambda * mean;
            r[j] = clamp_q16((v + 64'sd32768) >>> 16);
         end
      end
      res.x = int'(r[0]);
      res.y = int'(r[1]);
      res.z = int'(r[2]);
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, receiver stalls, result checker and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   int idle_cycles;

   always @(posedge clock) begin
      vertex_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[31:0];
            got.y = rsp_tdata[63:32];
            got.z = rsp_tdata[95:64];
            if (smoothed_q.size() == 0) begin
               report_mismatch($sformatf("result %h with no vertex pending", rsp_tdata));
            end else begin
               want = smoothed_q.pop_front();
               if (got.x != want.x)
                  report_mismatch($sformatf("out_x %h, want %h", got.x, want.x));
               if (got.y != want.y)
                  report_mismatch($sformatf("out_y %h, want %h", got.y, want.y));
               if (got.z != want.z)
                  report_mismatch($sformatf("out_z %h, want %h", got.z, want.z));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Present one item from the falling edge on, hold it until the transfer,
   // then advance the shadow.
   task automatic send_item(input int x, input int y, input int z,
                            input bit first, input bit last, input bit masked,
                            input bit has_fixed, input vertex_type fixed_res);
      vertex_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      req_tuser  <= {masked, first};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (smooth_step(x, y, z, first, last, masked, res))
         smoothed_q.push_back(has_fixed ? fixed_res : res);
   endtask

   // Drop valid, let every pending vertex arrive, then allow the block to
   // finish any item that produces no result.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (smoothed_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input longint value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[31:0];
      case (idx)
         CSR_KERNEL_MODE:     kern_mode     = value[1:0];
         CSR_RELAX_FACTOR:    lambda        = longint'($signed(value[18:0]));
         CSR_DISTANCE_OFFSET: dist_offset   = value[30:0];
         CSR_GAUSS_SCALE:     gauss_gain    = value[31:0];
         CSR_INCLUDE_CENTER:  centre_in_sum = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic apply_setting(input logic [1:0] mode, input longint lam,
                                input longint offs, input longint gain, input bit incl);
      write_reg(CSR_KERNEL_MODE, mode);
      write_reg(CSR_RELAX_FACTOR, lam);
      write_reg(CSR_DISTANCE_OFFSET, offs);
      write_reg(CSR_GAUSS_SCALE, gain);
      write_reg(CSR_INCLUDE_CENTER, incl);
   endtask

   // Centre near the origin most of the time, anywhere now and then.
   function automatic int pick_coord();
      if ($urandom_range(3) == 0) return int'($urandom);
      return int'($urandom) >>> $urandom_range(8, 31);
   endfunction

   // Neighbour offset: mostly within a few units so that every kernel gives
   // weights of interest, occasionally any size.
   function automatic int pick_offset();
      int s;
      s = ($urandom_range(3) != 0) ? $urandom_range(12, 19) : $urandom_range(0, 31);
      return int'($urandom) >>> (31 - s);
   endfunction

   // One vertex: centre, neighbours, closing mark; with some stray and
   // broken items mixed in.
   task automatic send_vertex(inout int count);
      vertex_type none, c;
      int      n;
      bit      masked;
      none = '{0, 0, 0};
      if ($urandom_range(9) == 0) begin
         send_item(int'($urandom), int'($urandom), int'($urandom), 1'b0,
                   $urandom_range(1), $urandom_range(1), 1'b0, none);
         count++;
         return;
      end
      n      = $urandom_range(0, 7);
      masked = ($urandom_range(11) == 0);
      c      = '{pick_coord(), pick_coord(), pick_coord()};
      send_item(c.x, c.y, c.z, 1'b1, n == 0, masked, 1'b0, none);
      count++;
      for (int k = 1; k <= n; k++) begin
         send_item(c.x + pick_offset(), c.y + pick_offset(), c.z + pick_offset(),
                   1'b0, k == n, $urandom_range(1), 1'b0, none);
         count++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Directed table, run under the reset settings (inverse distance,
   // lambda one, centre included, zero offset)
   // ---------------------------------------------------------------------
   localparam int MAXP = 32'h7FFF_FFFF;
   localparam int MINP = 32'h8000_0000;

   stim_row_type directed [] = '{
      // neighbour before any centre: adds against the reset centre
      '{32'h0001_0000, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
      '{0, 32'h0001_0000, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 0},
      // run of one item: centre weight is zero at zero offset, centre returned
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1, 1'b1, 1'b0,
        1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000},
      // masked centre is passed through
      '{MAXP, MINP, 0, 1'b1, 1'b1, 1'b1, 1'b1, MAXP, MINP, 0},
      '{MINP, MINP, MINP, 1'b1, 1'b0, 1'b1, 1'b0, 0, 0, 0},
      '{MAXP, MAXP, MAXP, 1'b0, 1'b1, 1'b1, 1'b1, MINP, MINP, MINP},
      // mask flag on a neighbour has no effect
      '{0, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 0},
      '{32'h0001_0000, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0, 0, 0, 0},
      '{0, 32'hFFFF_0000, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
      '{MAXP, MAXP, MAXP, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 0},
      // extreme distance
      '{MAXP, MAXP, MAXP, 1'b1, 1'b0, 1'b0, 1'b0, 0, 0, 0},
      '{MINP, MINP, MINP, 1'b0, 1'b1, 1'b1, 1'b0, 0, 0, 0},
      // a later closing item emits again from the kept sums
      '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 0}
   };

   initial begin
      vertex_type fixed_res;
      int      sent, target;
      longint  lam;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      req_tlast     = 1'b0;
      csr_wen       = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      send_idle_pct = 10;
      recv_idle_pct = 72;

      // reset state of the shadow
      kern_mode     = KERNEL_INVERSE;
      lambda        = 65536;
      dist_offset   = 0;
      gauss_gain    = 32768;
      centre_in_sum = 1'b1;
      for (int j = 0; j < 3; j++) begin
         centre_pos[j] = 0;
         wsum[j]       = 0;
      end
      wtotal        = 0;
      centre_masked = 1'b0;
      build_exp_samples();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         fixed_res = '{directed[i].ex, directed[i].ey, directed[i].ez};
         send_item(directed[i].x, directed[i].y, directed[i].z, directed[i].first,
                   directed[i].last, directed[i].masked, directed[i].has_fixed,
                   fixed_res);
      end
      drain();

      // eight settings, extremes first; stall pattern swaps at the fourth and stops at the seventh
      sent = 0;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 72;
            recv_idle_pct = 10;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: apply_setting(KERNEL_UNIFORM, 65536, 0, 32768, 1'b1);
            1: apply_setting(KERNEL_GAUSS, 32768, 0, 32768, 1'b0);
            2: apply_setting(KERNEL_INVERSE, -131072, 31'h7FFF_FFFF, 0, 1'b1);
            3: apply_setting(KERNEL_SPARE, 131072, 65536, 32'hFFFF_FFFF, 1'b1);
            4: apply_setting(KERNEL_INVERSE, -65536, 1, 65536, 1'b0);
            5: apply_setting(KERNEL_GAUSS, 0, 0, 0, 1'b1);
            default: begin
               lam = longint'($urandom_range(0, 262144)) - 131072;
               apply_setting($urandom_range(0, 3), lam, $urandom_range(0, 32'h0004_0000),
                             $urandom_range(0, 32'h0010_0000), $urandom_range(1));
            end
         endcase
         target = (RANDOM_ITEMS * (ph + 1)) / 8;
         while (sent < target) send_vertex(sent);
         drain();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wvs_pkg.sv
rtl/wvs_div.sv
rtl/wvs_exp_rom.sv
rtl/weighted_vertex_smoothing.sv
bench/weighted_vertex_smoothing_tb.sv
